// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the frame transmitter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CFUT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfut checker: same-cycle implication failed");

// Next-cycle implication, disabled during reset
`define CFUT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfut checker: next-cycle implication failed");

`endif

// File: rtl/core/cfut_pkg.sv
// ----------------------------------------------------------------------------
// cfut_pkg
// Codes, widths and the CRC16-CCITT byte step for the frame transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package cfut_pkg;

   // default sizes
   localparam int STORE_DEPTH_DEF = 256;
   localparam int FIFO_DEPTH_DEF  = 16;
   localparam int BYTE_RANGE      = 256;

   // field widths
   localparam int OP_W        = 3;
   localparam int KIND_W      = 2;
   localparam int ERR_W       = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
   localparam logic [OP_W-1:0] OP_BOUNDS = 3'd1;
   localparam logic [OP_W-1:0] OP_GO     = 3'd2;
   localparam logic [OP_W-1:0] OP_TICK   = 3'd3;
   localparam logic [OP_W-1:0] OP_STOP   = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [ERR_W-1:0] NO_ERROR    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_EMPTY   = 2'd0;
   localparam logic [ERR_W-1:0] ERR_BUSY    = 2'd1;
   localparam logic [ERR_W-1:0] ERR_STOPPED = 2'd2;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   // CRC16-CCITT, MSB first, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/cfut_ram.sv
// ----------------------------------------------------------------------------
// cfut_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfut_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/crc_framed_uart_transmitter.sv
// ----------------------------------------------------------------------------
// crc_framed_uart_transmitter
// Length-prefixed frame sender with CRC16-CCITT, feeding a transmit FIFO.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one command word per handshake (store write, set bounds, go,
//            FIFO-empty tick, stop). Operation in tuser, operands in tdata.
//   rsp_*  : result words: FIFO bytes, done or error. tlast marks the final
//            word caused by one command.
//   csr_*  : preamble byte write, always ready; write only while idle.
// Timing:
//   Commands without results (store write, set bounds, ignored codes,
//   go/stop while the UART is busy) leave req_tready high. A command with
//   results holds req_tready low until its last word is emitted; the
//   first word follows acceptance through the state register and then the
//   output register, then one word per cycle while rsp_tready allows (up to
//   FIFO_DEPTH words per command). The sequencer emits one word per cycle
//   through the single CRC byte unit and the store's registered read port.
// Reset (synchronous): bounds, CRC, phase and flags clear, preamble is zero,
//   no result pending. Store contents are undefined until written.
// Stall: when rsp_tready is low the word holds and the sequencer pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_uart_transmitter #(
   parameter int STORE_DEPTH = cfut_pkg::STORE_DEPTH_DEF,
   parameter int FIFO_DEPTH  = cfut_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // command channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [7:0] store_index, [15:8] store_value, [23:16] message_length,
   // [31:24] start_position, [32] uart_busy, [39:33] zero
   input  wire logic [cfut_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [2:0] operation
   input  wire logic [cfut_pkg::OP_W-1:0]        req_tuser,
   // result channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [7:0] tx_byte, [9:8] error_code, [15:10] zero
   output logic      [cfut_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [1:0] result_kind
   output logic      [cfut_pkg::KIND_W-1:0]      rsp_tuser,
   output logic                                  rsp_tlast,
   // preamble register
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [7:0]                       csr_data
);

   import cfut_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH);

   // byte index -> store address, modulo STORE_DEPTH
   typedef logic [AW-1:0] addr_tab_type [BYTE_RANGE];

   function automatic addr_tab_type build_addr_tab();
      addr_tab_type tab;
      int           r;
      r = 0;
      for (int v = 0; v < BYTE_RANGE; v++) begin
         tab[v] = AW'(r);
         r      = (r == STORE_DEPTH - 1) ? 0 : r + 1;
      end
      return tab;
   endfunction

   localparam addr_tab_type ADDR_TAB = build_addr_tab();

   typedef enum logic [1:0] {PH_IDLE, PH_BUSY, PH_EOT} phase_type;
   typedef enum logic [2:0] {
      SQ_IDLE, SQ_PRE, SQ_LEN, SQ_PAY, SQ_CRCH, SQ_CRCL, SQ_RES
   } seq_state_type;

   // command fields
   logic [OP_W-1:0] op;
   logic [7:0]      store_index;
   logic [7:0]      store_value;
   logic [7:0]      message_length;
   logic [7:0]      start_position;
   logic            uart_busy;

   assign op             = req_tuser;
   assign store_index    = req_tdata[7:0];
   assign store_value    = req_tdata[15:8];
   assign message_length = req_tdata[23:16];
   assign start_position = req_tdata[31:24];
   assign uart_busy      = req_tdata[32];

   // registers
   seq_state_type     state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [7:0]        end_ff, end_in;
   logic [7:0]        rdidx_ff, rdidx_in;
   logic [15:0]       crc_ff, crc_in;
   logic              busy_err_ff, busy_err_in;
   logic              stop_ff, stop_in;
   logic [7:0]        preamble_ff, preamble_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              crc_after_ff, crc_after_in;
   logic [KIND_W-1:0] res_kind_ff, res_kind_in;
   logic [ERR_W-1:0]  res_code_ff, res_code_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic [ERR_W-1:0]  rsp_code_ff, rsp_code_in;
   logic              rsp_last_ff, rsp_last_in;

   // store port
   logic          ram_wr_en;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   logic       req_accept;
   logic       slot_free;
   logic       abort;
   logic [8:0] n_diff;
   logic       n_empty;
   logic [7:0] diff8;
   logic [7:0] rdidx_next;

   assign req_tready = (state_ff == SQ_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign abort      = ((op == OP_GO) || (op == OP_STOP)) && (phase_ff != PH_IDLE);
   assign n_diff     = {1'b0, end_ff} - {1'b0, rdidx_ff};
   assign n_empty    = n_diff[8] || (n_diff[7:0] == 8'd0);
   assign diff8      = end_ff - rdidx_ff;
   assign rdidx_next = rdidx_ff + 8'd1;

   cfut_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_TAB[store_index]),
      .wr_data (store_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // command decode and word sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      end_in       = end_ff;
      rdidx_in     = rdidx_ff;
      crc_in       = crc_ff;
      busy_err_in  = busy_err_ff;
      stop_in      = stop_ff;
      cnt_in       = cnt_ff;
      crc_after_in = crc_after_ff;
      res_kind_in  = res_kind_ff;
      res_code_in  = res_code_ff;
      preamble_in  = csr_valid ? csr_data : preamble_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ADDR_TAB[rdidx_ff];

      if (req_accept) begin
         // prefetch the byte at read_index for a frame start or refill
         ram_rd_en = 1'b1;
         if (abort) begin
            busy_err_in = busy_err_ff || (op == OP_GO);
            stop_in     = stop_ff || (op == OP_STOP);
            if (uart_busy) begin
               phase_in = PH_EOT;
            end else begin
               res_kind_in = KIND_ERROR;
               res_code_in = (busy_err_ff || (op == OP_GO)) ? ERR_BUSY : ERR_STOPPED;
               busy_err_in = 1'b0;
               stop_in     = 1'b0;
               phase_in    = PH_IDLE;
               state_in    = SQ_RES;
            end
         end else begin
            unique case (op)
               OP_WRITE: begin
                  ram_wr_en = 1'b1;
               end
               OP_BOUNDS: begin
                  end_in   = message_length;
                  rdidx_in = start_position;
               end
               OP_GO: begin
                  // phase is idle here
                  crc_in = 16'h0000;
                  if (n_empty) begin
                     res_kind_in = KIND_ERROR;
                     res_code_in = ERR_EMPTY;
                     state_in    = SQ_RES;
                  end else if (n_diff[7:0] <= 8'(FIFO_DEPTH - 4)) begin
                     cnt_in       = CW'(n_diff[7:0]);
                     crc_after_in = 1'b1;
                     phase_in     = PH_EOT;
                     state_in     = SQ_PRE;
                  end else begin
                     cnt_in       = CW'(FIFO_DEPTH - 3);
                     crc_after_in = 1'b0;
                     phase_in     = PH_BUSY;
                     state_in     = SQ_PRE;
                  end
               end
               OP_TICK: begin
                  if (phase_ff == PH_BUSY) begin
                     if (diff8 <= 8'(FIFO_DEPTH - 2)) begin
                        cnt_in       = CW'(diff8);
                        crc_after_in = 1'b1;
                        phase_in     = PH_EOT;
                        state_in     = (diff8 == 8'd0) ? SQ_CRCH : SQ_PAY;
                     end else begin
                        cnt_in       = CW'(FIFO_DEPTH - 1);
                        crc_after_in = 1'b0;
                        state_in     = SQ_PAY;
                     end
                  end else if (phase_ff == PH_EOT) begin
                     res_kind_in = (busy_err_ff || stop_ff) ? KIND_ERROR : KIND_DONE;
                     res_code_in = busy_err_ff ? ERR_BUSY :
                                   (stop_ff ? ERR_STOPPED : NO_ERROR);
                     busy_err_in = 1'b0;
                     stop_in     = 1'b0;
                     phase_in    = PH_IDLE;
                     state_in    = SQ_RES;
                  end
               end
               default: begin
                  // stop in idle and undefined codes: no effect
               end
            endcase
         end
      end else if ((state_ff != SQ_IDLE) && slot_free) begin
         // emit one word
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_BYTE;
         rsp_byte_in  = 8'h00;
         rsp_code_in  = NO_ERROR;
         rsp_last_in  = 1'b0;
         unique case (state_ff)
            SQ_PRE: begin
               rsp_byte_in = preamble_ff;
               state_in    = SQ_LEN;
            end
            SQ_LEN: begin
               rsp_byte_in = diff8;
               state_in    = SQ_PAY;
            end
            SQ_PAY: begin
               // store byte through the CRC unit, fetch the next one
               rsp_byte_in = ram_rd_data;
               crc_in      = crc16_byte(crc_ff, ram_rd_data);
               rdidx_in    = rdidx_next;
               ram_rd_en   = 1'b1;
               ram_rd_addr = ADDR_TAB[rdidx_next];
               cnt_in      = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  rsp_last_in = !crc_after_ff;
                  state_in    = crc_after_ff ? SQ_CRCH : SQ_IDLE;
               end
            end
            SQ_CRCH: begin
               rsp_byte_in = crc_ff[15:8];
               state_in    = SQ_CRCL;
            end
            SQ_CRCL: begin
               rsp_byte_in = crc_ff[7:0];
               rsp_last_in = 1'b1;
               state_in    = SQ_IDLE;
            end
            SQ_RES: begin
               rsp_kind_in = res_kind_ff;
               rsp_code_in = res_code_ff;
               rsp_last_in = 1'b1;
               state_in    = SQ_IDLE;
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_tready;
            end
         endcase
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SQ_IDLE;
         phase_ff     <= PH_IDLE;
         end_ff       <= 8'h00;
         rdidx_ff     <= 8'h00;
         crc_ff       <= 16'h0000;
         busy_err_ff  <= 1'b0;
         stop_ff      <= 1'b0;
         preamble_ff  <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         end_ff       <= end_in;
         rdidx_ff     <= rdidx_in;
         crc_ff       <= crc_in;
         busy_err_ff  <= busy_err_in;
         stop_ff      <= stop_in;
         preamble_ff  <= preamble_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff       <= cnt_in;
      crc_after_ff <= crc_after_in;
      res_kind_ff  <= res_kind_in;
      res_code_ff  <= res_code_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - ERR_W - 8)'(0), rsp_code_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_ready  = 1'b1;

endmodule

`default_nettype wire

// File: rtl/core/cfut_checker.sv
// ----------------------------------------------------------------------------
// cfut_checker
// Port-level checks for the frame transmitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cfut_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic [cfut_pkg::OP_W-1:0]        req_tuser,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [cfut_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [cfut_pkg::KIND_W-1:0]      rsp_tuser,
   input wire logic                             rsp_tlast
);

   import cfut_pkg::*;

   logic                              req_accept;
   logic                              quiet_op;
   logic                              rsp_stall;
   logic                              status_word;
   logic                              plain_word;
   logic                              code_zero;
   logic [RSP_TDATA_W+KIND_W:0]       rsp_word;

   assign req_accept  = req_tvalid && req_tready;
   assign quiet_op    = (req_tuser == OP_WRITE) || (req_tuser == OP_BOUNDS);
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign status_word = rsp_tvalid && (rsp_tuser != KIND_BYTE);
   assign plain_word  = rsp_tvalid && (rsp_tuser != KIND_ERROR);
   assign code_zero   = (rsp_tdata[9:8] == NO_ERROR);
   assign rsp_word    = {rsp_tdata, rsp_tuser, rsp_tlast};

   // store writes and bound updates never block the command channel
   `CFUT_ASSERT_NEXT(a_quiet_op_ready, clock, reset, req_accept && quiet_op, req_tready)

   // done and error words always close the command
   `CFUT_ASSERT_IMPL(a_status_last, clock, reset, status_word, rsp_tlast)

   // error code only on error words
   `CFUT_ASSERT_IMPL(a_code_kind, clock, reset, plain_word, code_zero)

   // a stalled word holds
   `CFUT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

endmodule

bind crc_framed_uart_transmitter cfut_checker u_cfut_checker (.*);

`default_nettype wire
